FILE: rtl/pasc_pkg.sv
package pasc_pkg;

    // default sizes of the top level parameters
    localparam int COORD_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int SECTOR_BITS_DEF = 8;

    // internal angle: unsigned fraction of a full turn, 2^24 = 360 degrees
    localparam int TURN_BITS    = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int VEC_BITS     = 64;
    localparam int Z_BITS       = TURN_BITS + 1;
    localparam int QANG_BITS    = TURN_BITS - 1;
    localparam int ATAN_BITS    = 22;
    localparam int VEC_FRAC_TOP = 60;

    localparam logic signed [Z_BITS-1:0] QUARTER_Z = Z_BITS'(1) <<< (TURN_BITS - 2);
    localparam logic signed [Z_BITS-1:0] EIGHTH_Z  = Z_BITS'(1) <<< (TURN_BITS - 3);

    // configuration registers
    localparam int NUM_SECTORS_BITS = 9;
    localparam int RADIUS_BITS      = 15;
    localparam int CFG_ADDR_BITS    = 1;
    localparam int CFG_DATA_BITS    = 15;
    localparam int R2_BITS          = 2 * RADIUS_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_NUM_SECTORS = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS      = 1'b1;

    localparam logic [NUM_SECTORS_BITS-1:0] NUM_SECTORS_RESET = 9'd8;
    localparam logic [RADIUS_BITS-1:0]      RADIUS_RESET      = 15'd16;

    // atan(2^-i) in units of 2^-24 turn
    localparam logic [ATAN_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81,
        22'd41,      22'd20,      22'd10,     22'd5,
        22'd3,       22'd1,       22'd1,      22'd0
    };

    // rotating vector and accumulated angle
    typedef struct packed {
        logic signed [VEC_BITS-1:0] px;
        logic signed [VEC_BITS-1:0] py;
        logic signed [Z_BITS-1:0]   z;
    } vec_t;

    // per-point flags riding along the cells
    typedef struct packed {
        logic in_disc;
        logic xneg;
        logic yneg;
        logic hold;
    } side_t;

endpackage

FILE: rtl/pasc_front.sv
module pasc_front #(
    parameter int COORD_BITS = pasc_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          x_offset,
    input  logic [COORD_BITS-1:0]          y_offset,
    input  logic [pasc_pkg::R2_BITS-1:0]   r2,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pasc_pkg::vec_t                 out_vec,
    output pasc_pkg::side_t                out_side
);
    import pasc_pkg::*;

    localparam int PRESHIFT = VEC_FRAC_TOP - COORD_BITS;
    localparam int D2_BITS  = 2 * COORD_BITS + 1;
    localparam int CMP_BITS = (D2_BITS > R2_BITS) ? D2_BITS : R2_BITS;

    logic                    a_valid_reg;
    logic                    a_ready;
    logic [COORD_BITS-1:0]   a_ax_reg;
    logic [COORD_BITS-1:0]   a_ay_reg;
    logic                    a_xneg_reg;
    logic                    a_yneg_reg;

    logic                    b_valid_reg;
    logic                    b_ready;
    logic [COORD_BITS-1:0]   b_ax_reg;
    logic [COORD_BITS-1:0]   b_ay_reg;
    logic                    b_xneg_reg;
    logic                    b_yneg_reg;
    logic [2*COORD_BITS-1:0] b_sqx_reg;
    logic [2*COORD_BITS-1:0] b_sqy_reg;

    logic                    c_valid_reg;
    logic                    c_ready;
    vec_t                    c_vec_reg;
    side_t                   c_side_reg;

    logic [COORD_BITS-1:0]   ax_next;
    logic [COORD_BITS-1:0]   ay_next;
    logic [D2_BITS-1:0]      d2;
    logic                    in_disc;
    vec_t                    vec_next;
    side_t                   side_next;

    // handshake chain, a stage moves when empty or when its successor moves
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = !a_valid_reg || b_ready;

    // magnitudes, the most negative code maps to its unsigned magnitude
    assign ax_next = x_offset[COORD_BITS-1] ? (~x_offset + COORD_BITS'(1)) : x_offset;
    assign ay_next = y_offset[COORD_BITS-1] ? (~y_offset + COORD_BITS'(1)) : y_offset;

    // distance test and CORDIC start vector, exact directions bypass the cells
    always_comb
    begin
        d2 = D2_BITS'(b_sqx_reg) + D2_BITS'(b_sqy_reg);
        in_disc = !((b_ax_reg == '0) && (b_ay_reg == '0))
                  && (CMP_BITS'(d2) <= CMP_BITS'(r2));
        vec_next.px = $signed(VEC_BITS'(b_ax_reg) << PRESHIFT);
        vec_next.py = $signed(VEC_BITS'(b_ay_reg) << PRESHIFT);
        if (b_ay_reg == '0)
        begin
            vec_next.z = '0;
        end
        else if (b_ax_reg == '0)
        begin
            vec_next.z = QUARTER_Z;
        end
        else if (b_ax_reg == b_ay_reg)
        begin
            vec_next.z = EIGHTH_Z;
        end
        else
        begin
            vec_next.z = '0;
        end
        side_next.in_disc = in_disc;
        side_next.xneg    = b_xneg_reg;
        side_next.yneg    = b_yneg_reg;
        side_next.hold    = !in_disc || (b_ay_reg == '0) || (b_ax_reg == '0)
                            || (b_ax_reg == b_ay_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_ax_reg   <= ax_next;
            a_ay_reg   <= ay_next;
            a_xneg_reg <= x_offset[COORD_BITS-1];
            a_yneg_reg <= y_offset[COORD_BITS-1];
        end
        if (b_ready && a_valid_reg)
        begin
            b_ax_reg   <= a_ax_reg;
            b_ay_reg   <= a_ay_reg;
            b_xneg_reg <= a_xneg_reg;
            b_yneg_reg <= a_yneg_reg;
            b_sqx_reg  <= (2*COORD_BITS)'(a_ax_reg) * (2*COORD_BITS)'(a_ax_reg);
            b_sqy_reg  <= (2*COORD_BITS)'(a_ay_reg) * (2*COORD_BITS)'(a_ay_reg);
        end
        if (c_ready && b_valid_reg)
        begin
            c_vec_reg  <= vec_next;
            c_side_reg <= side_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_vec   = c_vec_reg;
    assign out_side  = c_side_reg;

endmodule

FILE: rtl/pasc_cell.sv
module pasc_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pasc_pkg::vec_t  in_vec,
    input  pasc_pkg::side_t in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output pasc_pkg::vec_t  out_vec,
    output pasc_pkg::side_t out_side
);
    import pasc_pkg::*;

    localparam logic signed [Z_BITS-1:0] ATAN_Z =
        $signed({{(Z_BITS-ATAN_BITS){1'b0}}, ATAN_TAB[STEP]});

    logic                       valid_reg;
    vec_t                       vec_reg;
    side_t                      side_reg;
    vec_t                       vec_next;
    logic signed [VEC_BITS-1:0] px;
    logic signed [VEC_BITS-1:0] py;
    logic signed [VEC_BITS-1:0] dx;
    logic signed [VEC_BITS-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    // one vectoring step, arithmetic shifts round toward minus infinity
    always_comb
    begin
        px = in_vec.px;
        py = in_vec.py;
        dx = py >>> STEP;
        dy = px >>> STEP;
        if (in_side.hold)
        begin
            vec_next = in_vec;
        end
        else if (!py[VEC_BITS-1])
        begin
            vec_next.px = px + dx;
            vec_next.py = py - dy;
            vec_next.z  = in_vec.z + ATAN_Z;
        end
        else
        begin
            vec_next.px = px - dx;
            vec_next.py = py + dy;
            vec_next.z  = in_vec.z - ATAN_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/pasc_back.sv
module pasc_back #(
    parameter int ANGLE_BITS  = pasc_pkg::ANGLE_BITS_DEF,
    parameter int SECTOR_BITS = pasc_pkg::SECTOR_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pasc_pkg::vec_t         in_vec,
    input  pasc_pkg::side_t        in_side,
    input  logic [SECTOR_BITS:0]   n_eff,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   in_disc,
    output logic [SECTOR_BITS-1:0] sector
);
    import pasc_pkg::*;

    localparam int PROD_BITS = ANGLE_BITS + SECTOR_BITS + 1;

    logic                       d_valid_reg;
    logic                       d_ready;
    logic                       d_in_disc_reg;
    logic [ANGLE_BITS-1:0]      d_ang_reg;

    logic                       e_valid_reg;
    logic                       e_ready;
    logic                       e_in_disc_reg;
    logic [PROD_BITS-1:0]       e_prod_reg;

    logic                       f_valid_reg;
    logic                       f_ready;
    logic                       f_in_disc_reg;
    logic [SECTOR_BITS-1:0]     f_sector_reg;

    logic [QANG_BITS-1:0]       qa;
    logic [Z_BITS-1:0]          full;
    logic [ANGLE_BITS:0]        ang_wide;
    logic [ANGLE_BITS-1:0]      ang_next;
    logic [SECTOR_BITS:0]       sec_wide;
    logic [SECTOR_BITS:0]       sec_lim;
    logic [SECTOR_BITS-1:0]     sector_next;

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    // clamp to the first quadrant, unfold by the signs, cut to the output angle
    always_comb
    begin
        if (in_vec.z[Z_BITS-1])
        begin
            qa = '0;
        end
        else if (in_vec.z > QUARTER_Z)
        begin
            qa = QANG_BITS'(QUARTER_Z);
        end
        else
        begin
            qa = in_vec.z[QANG_BITS-1:0];
        end
        if (in_side.xneg && !in_side.yneg)
        begin
            full = (Z_BITS'(1) << (TURN_BITS - 1)) - Z_BITS'(qa);
        end
        else if (in_side.xneg && in_side.yneg)
        begin
            full = (Z_BITS'(1) << (TURN_BITS - 1)) + Z_BITS'(qa);
        end
        else if (in_side.yneg)
        begin
            full = (Z_BITS'(1) << TURN_BITS) - Z_BITS'(qa);
        end
        else
        begin
            full = Z_BITS'(qa);
        end
        ang_wide = full[TURN_BITS -: (ANGLE_BITS + 1)];
        ang_next = ang_wide[ANGLE_BITS] ? '1 : ang_wide[ANGLE_BITS-1:0];
    end

    // sector from the registered product, limited to the last sector
    always_comb
    begin
        sec_wide = e_prod_reg[PROD_BITS-1:ANGLE_BITS];
        sec_lim  = (sec_wide >= n_eff) ? (n_eff - (SECTOR_BITS+1)'(1)) : sec_wide;
        sector_next = e_in_disc_reg ? sec_lim[SECTOR_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= in_valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_in_disc_reg <= in_side.in_disc;
            d_ang_reg     <= ang_next;
        end
        if (e_ready && d_valid_reg)
        begin
            e_in_disc_reg <= d_in_disc_reg;
            e_prod_reg    <= PROD_BITS'(d_ang_reg) * PROD_BITS'(n_eff);
        end
        if (f_ready && e_valid_reg)
        begin
            f_in_disc_reg <= e_in_disc_reg;
            f_sector_reg  <= sector_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign in_disc   = f_in_disc_reg;
    assign sector    = f_sector_reg;

endmodule

FILE: rtl/point_angle_sector_classifier.sv
// channel  | dir | beat content
// ---------+-----+-----------------------------------------------------------
// s_*      | in  | tdata: x_offset, y_offset (signed)
// m_*      | out | tdata: sector, tuser: in_disc
// cfg_*    | in  | cfg_addr 0 num_sectors, 1 radius; cfg_data low bits
//
// one point per cycle unless the output stalls, through the three front
// stages, the 24 CORDIC cells and the three back stages
// every stage moves when it is empty or its successor moves, so bubbles close
// up and input beats are taken while a result waits at the output register
// rst_n clears all valid bits and loads num_sectors 8 and radius 16
// radius squared is registered, it follows a radius write in the cycle after radius_reg takes it
module point_angle_sector_classifier #(
    parameter int COORD_BITS  = pasc_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS  = pasc_pkg::ANGLE_BITS_DEF,
    parameter int SECTOR_BITS = pasc_pkg::SECTOR_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // x_offset, y_offset from bit 0 up
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sector
    output logic [((SECTOR_BITS+7)/8)*8-1:0]       m_tdata,
    // in_disc
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pasc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [pasc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import pasc_pkg::*;

    localparam int M_TDATA_BITS = ((SECTOR_BITS + 7) / 8) * 8;
    localparam int NCMP_BITS    = (NUM_SECTORS_BITS > SECTOR_BITS + 2) ?
                                  NUM_SECTORS_BITS : SECTOR_BITS + 2;

    logic [NUM_SECTORS_BITS-1:0] num_sectors_reg;
    logic [RADIUS_BITS-1:0]      radius_reg;
    logic [R2_BITS-1:0]          r2_reg;
    logic [R2_BITS-1:0]          r2_next;
    logic [SECTOR_BITS:0]        n_eff;
    logic [NCMP_BITS-1:0]        n_ext;

    logic                        chain_valid [CORDIC_STEPS+1];
    logic                        chain_ready [CORDIC_STEPS+1];
    vec_t                        chain_vec   [CORDIC_STEPS+1];
    side_t                       chain_side  [CORDIC_STEPS+1];

    logic                        in_disc;
    logic [SECTOR_BITS-1:0]      sector;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sectors_reg <= NUM_SECTORS_RESET;
            radius_reg      <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_NUM_SECTORS: num_sectors_reg <= cfg_data[NUM_SECTORS_BITS-1:0];
                REG_RADIUS:      radius_reg      <= cfg_data[RADIUS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign r2_next = R2_BITS'(radius_reg) * R2_BITS'(radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_reg <= R2_BITS'(RADIUS_RESET) * R2_BITS'(RADIUS_RESET);
        end
        else
        begin
            r2_reg <= r2_next;
        end
    end

    // effective sector count: zero counts as one, capped at the index range
    always_comb
    begin
        n_ext = NCMP_BITS'(num_sectors_reg);
        if (n_ext == '0)
        begin
            n_eff = (SECTOR_BITS+1)'(1);
        end
        else if (n_ext > (NCMP_BITS'(1) << SECTOR_BITS))
        begin
            n_eff = (SECTOR_BITS+1)'(1) << SECTOR_BITS;
        end
        else
        begin
            n_eff = n_ext[SECTOR_BITS:0];
        end
    end

    // magnitudes, squares, distance test
    pasc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_offset  (s_tdata[COORD_BITS-1:0]),
        .y_offset  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .r2        (r2_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0]),
        .out_side  (chain_side[0])
    );

    // row of CORDIC cells, one rotation each
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        pasc_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // quadrant unfold, scaling to sectors, output register
    pasc_back #(
        .ANGLE_BITS  (ANGLE_BITS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_ready  (chain_ready[CORDIC_STEPS]),
        .in_vec    (chain_vec[CORDIC_STEPS]),
        .in_side   (chain_side[CORDIC_STEPS]),
        .n_eff     (n_eff),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .in_disc   (in_disc),
        .sector    (sector)
    );

    assign m_tdata = M_TDATA_BITS'(sector);
    assign m_tuser = in_disc;

    // an empty output register lets the whole chain take a beat
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready
    ) else $error("input stalled while the output register is empty");

    // a point outside the disc reports sector zero
    a_outside_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (sector == '0)
    ) else $error("nonzero sector for a point outside the disc");

    // the sector stays below the effective count
    a_sector_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((SECTOR_BITS+1)'(sector) < n_eff)
    ) else $error("sector beyond the sector count");

    // radius squared follows the radius register while the radius is stable
    a_r2_tracks: assert property (
        @(posedge clk) disable iff (!rst_n)
        $stable(radius_reg) |-> (r2_reg == r2_next)
    ) else $error("radius squared out of step with the radius");

endmodule

FILE: tb/point_sector_checker.sv
module point_sector_checker (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    // x_offset, y_offset from bit 0 up
    input  logic [((2*pasc_pkg::COORD_BITS_DEF+7)/8)*8-1:0]          s_tdata,
    input  logic                                                     s_tvalid,
    input  logic                                                     s_tready,
    // sector
    input  logic [((pasc_pkg::SECTOR_BITS_DEF+7)/8)*8-1:0]           m_tdata,
    // in_disc
    input  logic                                                     m_tuser,
    input  logic                                                     m_tvalid,
    input  logic                                                     m_tready,
    input  logic                                                     cfg_valid,
    input  logic                                                     cfg_ready,
    input  logic [pasc_pkg::CFG_ADDR_BITS-1:0]                       cfg_addr,
    input  logic [pasc_pkg::CFG_DATA_BITS-1:0]                       cfg_data,
    output int                                                       results_due,
    output int                                                       mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pasc_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int ANGLE_BITS  = ANGLE_BITS_DEF;
    localparam int SECTOR_BITS = SECTOR_BITS_DEF;
    localparam int MDATA_BITS  = ((SECTOR_BITS + 7) / 8) * 8;
    localparam int PRESHIFT    = VEC_FRAC_TOP - COORD_BITS;
    localparam int ROT_STEPS   = 24;

    localparam longint QUARTER_TURN = 64'sd1 <<< (TURN_BITS - 2);
    localparam longint HALF_TURN    = 64'sd1 <<< (TURN_BITS - 1);
    localparam longint FULL_TURN    = 64'sd1 <<< TURN_BITS;
    localparam longint ANGLE_MAX    = (64'sd1 <<< ANGLE_BITS) - 1;
    localparam longint SECTOR_SPAN  = 64'sd1 <<< SECTOR_BITS;

    // atan(2^-i) in 2^-24 turn units, rounded to nearest
    localparam int ATAN_STEP [ROT_STEPS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic                   in_disc;
        logic [SECTOR_BITS-1:0] sector;
    } sector_result_t;

    logic [NUM_SECTORS_BITS-1:0] num_sectors_q;
    logic [RADIUS_BITS-1:0]      radius_q;
    sector_result_t              expected_q [$];

    // disc test, quadrant angle by vectoring rotation, then sector binning
    function automatic sector_result_t classify_point(
        input logic [COORD_BITS-1:0]       xr,
        input logic [COORD_BITS-1:0]       yr,
        input logic [NUM_SECTORS_BITS-1:0] nsec,
        input logic [RADIUS_BITS-1:0]      rad
    );
        sector_result_t res;
        longint x, y, ax, ay, px, py, dx, dy, z, full, ang, n, sec;
        res = '0;
        x   = longint'($signed(xr));
        y   = longint'($signed(yr));
        ax  = (x < 0) ? -x : x;
        ay  = (y < 0) ? -y : y;
        if ((ax == 0 && ay == 0) || ax * ax + ay * ay > longint'(rad) * longint'(rad))
            return res;

        // axis and diagonal points skip the rotation
        if (ay == 0)
            z = 0;
        else if (ax == 0)
            z = QUARTER_TURN;
        else if (ax == ay)
            z = QUARTER_TURN / 2;
        else
        begin
            px = ax <<< PRESHIFT;
            py = ay <<< PRESHIFT;
            z  = 0;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0)
                begin
                    px += dx;
                    py -= dy;
                    z  += ATAN_STEP[i];
                end
                else
                begin
                    px -= dx;
                    py += dy;
                    z  -= ATAN_STEP[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > QUARTER_TURN)
                z = QUARTER_TURN;
        end

        // place the angle in its quadrant
        if (x < 0 && y >= 0)
            full = HALF_TURN - z;
        else if (x < 0 && y < 0)
            full = HALF_TURN + z;
        else if (x >= 0 && y < 0)
            full = FULL_TURN - z;
        else
            full = z;

        ang = full >>> (TURN_BITS - ANGLE_BITS);
        if (ang > ANGLE_MAX)
            ang = ANGLE_MAX;

        // zero sectors act as one, counts above the field range saturate
        n = longint'(nsec);
        if (n == 0)
            n = 1;
        if (n > SECTOR_SPAN)
            n = SECTOR_SPAN;
        sec = (ang * n) >>> ANGLE_BITS;
        if (sec >= n)
            sec = n - 1;

        res.in_disc = 1'b1;
        res.sector  = SECTOR_BITS'(sec);
        return res;
    endfunction

    // track register writes, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        sector_result_t want;
        int             errs;
        if (!rst_n)
        begin
            num_sectors_q <= NUM_SECTORS_RESET;
            radius_q      <= RADIUS_RESET;
            expected_q.delete();
            results_due    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == REG_NUM_SECTORS)
                    num_sectors_q <= cfg_data[NUM_SECTORS_BITS-1:0];
                else if (cfg_addr == REG_RADIUS)
                    radius_q <= cfg_data[RADIUS_BITS-1:0];
            end

            if (s_tvalid && s_tready)
                expected_q = {expected_q,
                              classify_point(s_tdata[COORD_BITS-1:0],
                                             s_tdata[2*COORD_BITS-1:COORD_BITS],
                                             num_sectors_q, radius_q)};

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result beat: in_disc %0d sector %0d", m_tuser, m_tdata);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.in_disc)
                    begin
                        $error("in_disc mismatch: expected %0d, got %0d", want.in_disc, m_tuser);
                        errs++;
                    end
                    if (m_tdata !== MDATA_BITS'(want.sector))
                    begin
                        $error("sector mismatch: expected %0d, got %0d", want.sector, m_tdata);
                        errs++;
                    end
                end
            end

            results_due    <= expected_q.size();
            mismatch_count <= mismatch_count + errs;
        end
    end

endmodule

FILE: tb/tb_point_angle_sector_classifier.sv
module tb_point_angle_sector_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import pasc_pkg::*;

    localparam int SDATA_BITS      = ((2 * COORD_BITS_DEF + 7) / 8) * 8;
    localparam int MDATA_BITS      = ((SECTOR_BITS_DEF + 7) / 8) * 8;
    localparam int PHASE_ITEMS     = 95;
    localparam int BACKLOG_ITEMS   = 60;
    localparam int RX_HOLD_CYCLES  = 250;
    localparam int SETTLE_CYCLES   = 40;
    localparam int QUIET_LIMIT     = 5000;
    localparam int MAX_COORD       = 32767;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic [SDATA_BITS-1:0]         s_tdata   = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [MDATA_BITS-1:0]         m_tdata;
    logic                          m_tuser;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_ADDR_BITS-1:0]      cfg_addr  = REG_NUM_SECTORS;
    logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;

    int                            results_due;
    int                            mismatch_count;
    int                            send_idle_pct = 23;
    int                            recv_idle_pct = 82;
    int                            cur_radius    = 16;
    logic                          hold_rx       = 1'b0;
    int                            hold_count    = 0;
    int                            quiet_cycles  = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    point_angle_sector_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    point_sector_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    // result side: random stalls, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_rx && hold_count < RX_HOLD_CYCLES)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            if (!hold_rx)
                hold_count <= 0;
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one point beat, with random idle cycles ahead of it
    task automatic send_point(input logic [COORD_BITS_DEF-1:0] x,
                              input logic [COORD_BITS_DEF-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SDATA_BITS'({y, x});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering points and wait for every result in flight
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // write both registers once the block is empty, radius first
    task automatic load_config(input logic [NUM_SECTORS_BITS-1:0] nsec,
                               input logic [RADIUS_BITS-1:0] rad);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_addr  <= REG_RADIUS;
        cfg_data  <= CFG_DATA_BITS'(rad);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // upper data bits are junk the block must ignore
        cfg_addr  <= REG_NUM_SECTORS;
        cfg_data  <= {(CFG_DATA_BITS - NUM_SECTORS_BITS)'($urandom()), nsec};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        cur_radius = int'(rad);
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return MAX_COORD;
        endcase
    endfunction

    // random points, mostly near the disc so that in and out both occur
    task automatic run_random(input int count);
        int lim, k, v, px, py;
        for (int i = 0; i < count; i++)
        begin
            lim = (cur_radius + 2 > MAX_COORD) ? MAX_COORD : cur_radius + 2;
            k   = $urandom_range(99);
            if (k < 55)
            begin
                px = $urandom_range(2 * lim) - lim;
                py = $urandom_range(2 * lim) - lim;
            end
            else if (k < 65)
            begin
                v = $urandom_range(2 * lim) - lim;
                if ($urandom_range(1))
                begin
                    px = v;
                    py = 0;
                end
                else
                begin
                    px = 0;
                    py = v;
                end
            end
            else if (k < 75)
            begin
                v  = $urandom_range(lim);
                px = $urandom_range(1) ? v : -v;
                py = $urandom_range(1) ? v : -v;
            end
            else if (k < 90)
            begin
                px = $urandom();
                py = $urandom();
            end
            else
            begin
                px = extreme_coord();
                py = extreme_coord();
            end
            send_point(COORD_BITS_DEF'(px), COORD_BITS_DEF'(py));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points over the widest disc and the finest sectors
        load_config(9'd256, 15'd32767);
        send_point(16'd0, 16'd0);
        send_point(16'd100, 16'd0);
        send_point(-16'sd100, 16'd0);
        send_point(16'd0, 16'd100);
        send_point(16'd0, -16'sd100);
        send_point(16'd7, 16'd7);
        send_point(-16'sd7, 16'd7);
        send_point(-16'sd7, -16'sd7);
        send_point(16'd7, -16'sd7);
        send_point(16'd32767, 16'd0);
        send_point(16'd0, -16'sd32767);
        send_point(16'h8000, 16'd0);
        send_point(16'h8000, 16'h8000);
        send_point(16'd32767, 16'd32767);
        send_point(16'd23169, 16'd23169);
        send_point(16'd23170, -16'sd23170);
        send_point(16'd32767, -16'sd1);
        send_point(16'd1, -16'sd32767);
        send_point(-16'sd32767, 16'd1);
        send_point(16'd3, 16'd4);
        send_point(-16'sd4, 16'd3);
        send_point(16'd2, -16'sd1);

        // slow receiver
        send_idle_pct = 23;
        recv_idle_pct = 82;
        load_config(9'd8, 15'd16);
        run_random(PHASE_ITEMS);
        load_config(9'd0, 15'd300);
        run_random(PHASE_ITEMS);

        // slow sender
        send_idle_pct = 82;
        recv_idle_pct = 23;
        load_config(9'd511, 15'd32767);
        run_random(PHASE_ITEMS);
        load_config(9'd5, 15'd0);
        run_random(PHASE_ITEMS);

        // no idling; first a long hold-off so the pipeline backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(9'd256, 15'd40);
        hold_rx <= 1'b1;
        run_random(BACKLOG_ITEMS);
        hold_rx <= 1'b0;
        load_config(9'd1, 15'd100);
        run_random(PHASE_ITEMS);
        load_config(NUM_SECTORS_BITS'($urandom_range(511)), RADIUS_BITS'($urandom_range(32767)));
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pasc_pkg.sv
rtl/pasc_front.sv
rtl/pasc_cell.sv
rtl/pasc_back.sv
rtl/point_angle_sector_classifier.sv
tb/point_sector_checker.sv
tb/tb_point_angle_sector_classifier.sv
